>>> hw/rtl/echo_ncs_pkg.sv
// Shared types, codes and helper functions of the echo node count step block.
package echo_ncs_pkg;

	// Node ids are four bits wide, so at most this many nodes can be addressed.
	localparam int NODE_ID_SPACE = 16;
	localparam int MAX_NODES_DEF = 16;
	localparam int COUNT_W       = 8;
	localparam int ADDR_W        = 3;
	localparam int DATA_W        = 32;
	localparam int MASK_W        = 16;

	// Register index decoded from paddr[2]
	localparam logic REG_NEIGHBOR_MASK = 1'b0;

	// Incoming message kinds
	localparam logic [1:0] KIND_START    = 2'd0;
	localparam logic [1:0] KIND_TRAVERSE = 2'd1;
	localparam logic [1:0] KIND_RETURN   = 2'd2;

	// Outgoing message kinds
	localparam logic [1:0] MSG_TRAVERSE = 2'd0;
	localparam logic [1:0] MSG_RETURN   = 2'd1;
	localparam logic [1:0] MSG_FINAL    = 2'd2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

	typedef struct packed {
		logic [1:0]         kind;
		logic [3:0]         source;
		logic [COUNT_W-1:0] carried_count;
	} item_t;

	typedef struct packed {
		logic [3:0]         destination;
		logic [1:0]         message_kind;
		logic [COUNT_W-1:0] count_out;
		logic               last;
	} result_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;      // item taken this cycle
		logic emit_flood;  // next flood traverse goes to the output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic has_result;  // accepted item gives at least one result
		logic first_more;  // accepted item starts a flood of more than one
		logic flood_more;  // flood has more after the one being emitted
	} sts_t;

	typedef enum logic {
		ST_IDLE,
		ST_FLOOD
	} state_t;

	// Saturating add of two counts
	function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
			input logic [COUNT_W-1:0] b);
		logic [COUNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
	endfunction

	// Id of the lowest set bit; 0 for an empty mask
	function automatic logic [3:0] low_index(input logic [MASK_W-1:0] m);
		logic [3:0] idx;
		idx = '0;
		for (int i = MASK_W - 1; i >= 0; i--) begin
			if (m[i]) idx = 4'(i);
		end
		return idx;
	endfunction

endpackage

>>> hw/rtl/echo_node_count_step_core.sv
// Top level of the echo node count step block: ports, register decode, submodules.
//
// One network node of an echo traversal that counts nodes.
// item channel: kind (start, traverse, return), source node id and carried count.
// result channel: destination, message kind, count and a last flag on the final
// result of each item. Both channels move an item when valid is high and stall low.
// neighbor_mask is to be written over the APB port only while the block is idle;
// the block itself does not enforce this. The write also reloads the
// pending-neighbor mask. The first result of an item is in the output register in
// the cycle after the item is taken. The flood sequencer gives the traverse
// messages of a flood one result a cycle while the output is not stalled; every
// other item gives at most one result. A new item is taken once the previous
// item's results have all entered the output register and that register is free
// or being drained.
// Reset clears the node state, the neighbor mask and the output valid.
// A stalled result holds its payload; the flood waits and the item channel stalls.
module echo_node_count_step_core #(
	parameter int MAX_NODES = echo_ncs_pkg::MAX_NODES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [echo_ncs_pkg::ADDR_W-1:0]   paddr,
	input  logic [echo_ncs_pkg::DATA_W-1:0]   pwdata,
	output logic [echo_ncs_pkg::DATA_W-1:0]   prdata,
	output logic                              pready,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  echo_ncs_pkg::item_t               item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output echo_ncs_pkg::result_t             result
);
	import echo_ncs_pkg::*;

	cmd_t              cmd;
	sts_t              sts;
	logic              cfg_we;
	logic [MASK_W-1:0] neighbor_mask;

	// Register port: one register, no wait states
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_NEIGHBOR_MASK);
	assign prdata = (paddr[2] == REG_NEIGHBOR_MASK) ? DATA_W'(neighbor_mask) : '0;

	echo_ncs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	echo_ncs_dp #(
		.MAX_NODES (MAX_NODES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (pwdata[MASK_W-1:0]),
		.neighbor_mask (neighbor_mask),
		.item          (item),
		.result        (result),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule

>>> hw/rtl/echo_ncs_ctrl.sv
// Controller: sequences item acceptance and the traverse flood, owns output valid.
module echo_ncs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	output logic                result_valid,
	input  logic                result_stall,
	input  echo_ncs_pkg::sts_t  sts,
	output echo_ncs_pkg::cmd_t  cmd
);
	import echo_ncs_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   load_out;

	// Output register can take a new result when empty or being drained
	assign out_free     = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid && out_free && sts.first_more) state_d = ST_FLOOD;
			end
			ST_FLOOD: begin
				if (out_free && !sts.flood_more) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs and commands
	always_comb begin
		item_stall     = 1'b1;
		cmd.accept     = 1'b0;
		cmd.emit_flood = 1'b0;
		load_out       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = !out_free;
				cmd.accept = item_valid && out_free;
				load_out   = cmd.accept && sts.has_result;
			end
			ST_FLOOD: begin
				cmd.emit_flood = out_free;
				load_out       = out_free;
			end
			default: ;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_free) out_valid_q <= load_out;
		end
	end

endmodule

>>> hw/rtl/echo_ncs_dp.sv
// Datapath: node state, message decode, flood mask and output register.
module echo_ncs_dp #(
	parameter int MAX_NODES = echo_ncs_pkg::MAX_NODES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [echo_ncs_pkg::MASK_W-1:0]      cfg_wdata,
	output logic [echo_ncs_pkg::MASK_W-1:0]      neighbor_mask,
	input  echo_ncs_pkg::item_t                  item,
	output echo_ncs_pkg::result_t                result,
	input  echo_ncs_pkg::cmd_t                   cmd,
	output echo_ncs_pkg::sts_t                   sts
);
	import echo_ncs_pkg::*;

	// Only node ids below both limits can be pending
	localparam int PEND_W = (MAX_NODES < NODE_ID_SPACE) ? MAX_NODES : NODE_ID_SPACE;

	logic [MASK_W-1:0]  neighbor_q;
	logic [PEND_W-1:0]  pending_q;
	logic               visited_q;
	logic               parent_valid_q;
	logic [3:0]         parent_id_q;
	logic [COUNT_W-1:0] count_q;
	logic               finished_q;
	logic [PEND_W-1:0]  flood_q;
	result_t            result_q;

	logic [PEND_W-1:0]  src_bit;
	logic [PEND_W-1:0]  pend_rm;
	logic [COUNT_W-1:0] cnt_ret;
	logic [COUNT_W-1:0] cnt_done;

	logic               nxt_visited;
	logic               nxt_parent_valid;
	logic [3:0]         nxt_parent_id;
	logic [PEND_W-1:0]  nxt_pending;
	logic [COUNT_W-1:0] nxt_count;
	logic               nxt_finished;
	logic               do_flood;
	logic               single;
	logic [PEND_W-1:0]  flood_src;
	logic [PEND_W-1:0]  flood_src_rest;
	logic [PEND_W-1:0]  flood_rest;
	result_t            acc_res;
	result_t            flood_res;

	assign neighbor_mask = neighbor_q;
	assign result        = result_q;

	// Source bit; an id beyond the pending width removes nothing
	always_comb begin
		src_bit = '0;
		for (int i = 0; i < PEND_W; i++) begin
			src_bit[i] = (item.source == 4'(i));
		end
	end

	assign pend_rm  = pending_q & ~src_bit;
	assign cnt_ret  = sat_add(count_q, item.carried_count);
	// Node adds itself on completion; a return first adds its carried count
	assign cnt_done = sat_add((item.kind == KIND_RETURN) ? cnt_ret : count_q, COUNT_W'(1));

	// Decode of an item against the node state
	always_comb begin
		nxt_visited      = visited_q;
		nxt_parent_valid = parent_valid_q;
		nxt_parent_id    = parent_id_q;
		nxt_pending      = pending_q;
		nxt_count        = count_q;
		nxt_finished     = finished_q;
		do_flood         = 1'b0;
		single           = 1'b0;
		flood_src        = pending_q;
		acc_res          = '{destination: '0, message_kind: MSG_RETURN,
		                     count_out: '0, last: 1'b1};
		if (!finished_q) begin
			unique case (item.kind)
				KIND_START: begin
					if (!visited_q) begin
						nxt_visited = 1'b1;
						if (pending_q == '0) begin
							// Alone: complete at once
							nxt_count    = cnt_done;
							nxt_finished = 1'b1;
							single       = 1'b1;
							acc_res.destination  = parent_valid_q ? parent_id_q : 4'd0;
							acc_res.message_kind = parent_valid_q ? MSG_RETURN : MSG_FINAL;
							acc_res.count_out    = cnt_done;
						end else begin
							do_flood = 1'b1;
						end
					end
				end
				KIND_TRAVERSE: begin
					nxt_pending = pend_rm;
					single      = 1'b1;
					acc_res.destination = item.source;
					if (!visited_q) begin
						nxt_visited      = 1'b1;
						nxt_parent_valid = 1'b1;
						nxt_parent_id    = item.source;
						if (pend_rm == '0) begin
							// Leaf answers its parent with one
							nxt_finished      = 1'b1;
							acc_res.count_out = COUNT_W'(1);
						end else begin
							single    = 1'b0;
							do_flood  = 1'b1;
							flood_src = pend_rm;
						end
					end
				end
				KIND_RETURN: begin
					nxt_pending = pend_rm;
					nxt_count   = cnt_ret;
					if (pend_rm == '0) begin
						nxt_count    = cnt_done;
						nxt_finished = 1'b1;
						single       = 1'b1;
						acc_res.destination  = parent_valid_q ? parent_id_q : 4'd0;
						acc_res.message_kind = parent_valid_q ? MSG_RETURN : MSG_FINAL;
						acc_res.count_out    = cnt_done;
					end
				end
				default: ;
			endcase
		end
		// First traverse of a flood
		flood_src_rest = flood_src & (flood_src - PEND_W'(1));
		if (do_flood) begin
			acc_res.destination  = low_index(MASK_W'(flood_src));
			acc_res.message_kind = MSG_TRAVERSE;
			acc_res.count_out    = '0;
			acc_res.last         = (flood_src_rest == '0);
		end
	end

	// Next traverse from the remaining flood mask
	assign flood_rest = flood_q & (flood_q - PEND_W'(1));
	always_comb begin
		flood_res.destination  = low_index(MASK_W'(flood_q));
		flood_res.message_kind = MSG_TRAVERSE;
		flood_res.count_out    = '0;
		flood_res.last         = (flood_rest == '0);
	end

	assign sts.has_result = single || do_flood;
	assign sts.first_more = do_flood && (flood_src_rest != '0);
	assign sts.flood_more = (flood_rest != '0);

	// Node state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neighbor_q     <= '0;
			pending_q      <= '0;
			visited_q      <= 1'b0;
			parent_valid_q <= 1'b0;
			parent_id_q    <= '0;
			count_q        <= '0;
			finished_q     <= 1'b0;
		end else if (cfg_we) begin
			neighbor_q <= cfg_wdata;
			pending_q  <= cfg_wdata[PEND_W-1:0];
		end else if (cmd.accept) begin
			pending_q      <= nxt_pending;
			visited_q      <= nxt_visited;
			parent_valid_q <= nxt_parent_valid;
			parent_id_q    <= nxt_parent_id;
			count_q        <= nxt_count;
			finished_q     <= nxt_finished;
		end
	end

	// Flood mask and output payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			flood_q  <= flood_src_rest;
			result_q <= acc_res;
		end else if (cmd.emit_flood) begin
			flood_q  <= flood_rest;
			result_q <= flood_res;
		end
	end

endmodule

>>> hw/rtl/echo_ncs_checker.sv
// Port-level checks of the echo node count step block, bound to the top level.
module echo_ncs_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  item_valid,
	input logic                  item_stall,
	input logic                  result_valid,
	input logic                  result_stall,
	input echo_ncs_pkg::result_t result
);
	import echo_ncs_pkg::*;

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// An item is only taken when the output register can take its result
	a_take_free: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |-> !result_valid || !result_stall)
		else $error("item taken while result blocked");

	// Traverse messages carry no count
	a_trav_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.message_kind == MSG_TRAVERSE |-> result.count_out == '0)
		else $error("traverse with nonzero count");

	// The total report is a single last result addressed to node zero
	a_final: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.message_kind == MSG_FINAL
			|-> result.last && result.destination == 4'd0)
		else $error("malformed final report");

	// No unused message kind appears
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.message_kind == MSG_TRAVERSE ||
			result.message_kind == MSG_RETURN || result.message_kind == MSG_FINAL)
		else $error("bad message kind");

endmodule

bind echo_node_count_step_core echo_ncs_checker u_echo_ncs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

>>> dv/testbench.sv
// Self-checking testbench for the echo node count step core: table-driven and random items.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import echo_ncs_pkg::*;

	localparam int PERIOD      = 10;
	localparam int SETTLE      = 4;     // settle wait before the neighbor register is written
	localparam int TAIL        = 40;
	localparam int HOLD_AT     = 40;    // items taken before the long result stall
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 3000;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 52;    // traverse and return items per phase
	localparam int ROWS        = 12;

	// Kind code the block has no use for
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam result_t    NO_MSG      = '0;

	// One row of the directed table; the expectation is typed in when typed is set
	typedef struct packed {
		logic        load;
		logic [15:0] mask;
		item_t       it;
		logic        typed;
		logic        n_want;
		result_t     want;
	} plan_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                item_valid = 1'b0;
	logic                item_stall;
	item_t               item = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	result_t             result;

	// Predicted node state and its copy of the neighbor register
	logic        seen = 1'b0;
	logic        has_parent = 1'b0;
	logic [3:0]  parent = '0;
	logic [15:0] nbr_mask = '0;
	logic [15:0] awaiting = '0;
	logic [7:0]  tally = '0;
	logic        done_node = 1'b0;

	result_t     fresh [16];            // messages caused by the latest item
	int          fresh_n;
	result_t     due_msgs [$];          // messages still owed by the block
	plan_row_t   plan [ROWS];
	int          took_items = 0;
	int          burst_left = 0;
	int          quiet = 0;
	int          errors = 0;

	echo_node_count_step_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #(PERIOD / 2) clk = ~clk;

	// Messages the node sends for one item; updates the predicted state
	function automatic void predict_replies(input item_t it);
		logic       flood;
		logic       wrap_up;
		logic [8:0] sum;
		int         i;
		fresh_n = 0;
		flood = 1'b0;
		wrap_up = 1'b0;
		if (done_node) return;
		case (it.kind)
			KIND_START: begin
				if (!seen) begin
					seen = 1'b1;
					if (awaiting == '0) wrap_up = 1'b1;
					else flood = 1'b1;
				end
			end
			KIND_TRAVERSE: begin
				awaiting[it.source] = 1'b0;
				if (!seen) begin
					seen = 1'b1;
					has_parent = 1'b1;
					parent = it.source;
					// a leaf answers its parent at once
					if (awaiting == '0) begin
						done_node = 1'b1;
						fresh[0] = {parent, MSG_RETURN, 8'd1, 1'b1};
						fresh_n = 1;
					end else begin
						flood = 1'b1;
					end
				end else begin
					fresh[0] = {it.source, MSG_RETURN, 8'd0, 1'b1};
					fresh_n = 1;
				end
			end
			KIND_RETURN: begin
				awaiting[it.source] = 1'b0;
				sum = {1'b0, tally} + {1'b0, it.carried_count};
				tally = sum[8] ? 8'hFF : sum[7:0];
				wrap_up = (awaiting == '0);
			end
			default: ;
		endcase
		// traverse to every pending neighbor, lowest id first
		if (flood) begin
			for (i = 0; i < 16; i++) begin
				if (awaiting[i]) begin
					fresh[fresh_n] = {4'(i), MSG_TRAVERSE, 8'd0,
						(awaiting >> (i + 1)) == 16'd0};
					fresh_n++;
				end
			end
		end
		// count this node and report upward
		if (wrap_up) begin
			tally = (tally == 8'hFF) ? tally : tally + 8'd1;
			done_node = 1'b1;
			fresh[0] = has_parent ? {parent, MSG_RETURN, tally, 1'b1}
				: {4'd0, MSG_FINAL, tally, 1'b1};
			fresh_n = 1;
		end
	endfunction

	// Offer one item, record what it owes once taken, then maybe pause
	task automatic send_item(input item_t it, input logic typed, input logic n_want,
			input result_t want);
		int k;
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		predict_replies(it);
		if (typed) begin
			if (n_want) due_msgs.push_back(want);
		end else begin
			for (k = 0; k < fresh_n; k++) due_msgs.push_back(fresh[k]);
		end
		took_items++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 8);
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Write the neighbor register once the block has gone quiet, then read it back
	task automatic load_neighbors(input logic [15:0] m);
		item_valid <= 1'b0;
		while (due_msgs.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {REG_NEIGHBOR_MASK, 2'b00};
		pwdata  <= DATA_W'(m);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		nbr_mask = m;
		awaiting = nbr_mask;
		// read cycle
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== DATA_W'(nbr_mask)) begin
			$display("%0t: register mismatch: expected %0h got %0h", $time,
				DATA_W'(nbr_mask), prdata);
			errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Result checker and activity counter for the watchdog
	always @(posedge clk) begin : check_results
		result_t want;
		if ((item_valid && !item_stall) || (result_valid && !result_stall)
				|| (psel && penable && pwrite && pready))
			quiet = 0;
		else
			quiet++;
		if (result_valid && !result_stall) begin
			if (due_msgs.size() == 0) begin
				$display("%0t: unexpected result dst=%0d kind=%0d count=%0d last=%0b", $time,
					result.destination, result.message_kind, result.count_out, result.last);
				errors++;
			end else begin
				want = due_msgs.pop_front();
				if (result.destination !== want.destination
						|| result.message_kind !== want.message_kind
						|| result.count_out !== want.count_out
						|| result.last !== want.last) begin
					$display("%0t: result mismatch: expected dst=%0d kind=%0d count=%0d last=%0b",
						$time, want.destination, want.message_kind, want.count_out, want.last);
					$display("%0t:                  got      dst=%0d kind=%0d count=%0d last=%0b",
						$time, result.destination, result.message_kind, result.count_out,
						result.last);
					errors++;
				end
			end
		end
	end

	// Receiver: stretches of no, light and heavy stalls, plus one long hold-off
	initial begin : receiver
		int span;
		int pct;
		logic held;
		held = 1'b0;
		wait (arst_n);
		forever begin
			if (!held && took_items >= HOLD_AT) begin
				held = 1'b1;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			span = $urandom_range(4, 40);
			case ($urandom_range(0, 2))
				0: pct = 0;
				1: pct = 30;
				default: pct = 75;
			endcase
			repeat (span) begin
				result_stall <= ($urandom_range(1, 100) <= pct);
				@(posedge clk);
			end
		end
	end

	initial begin : watchdog
		while (quiet < QUIET_LIMIT) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		item_t       pick;
		item_t       first_visit;
		logic [15:0] m;
		int          n;
		int          ph;
		int          counted;
		int          r;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The first visit makes this node either the root or a child of a random sender
		if ($urandom_range(0, 1))
			first_visit = {KIND_START, 4'd0, 8'd0};
		else
			first_visit = {KIND_TRAVERSE, 4'($urandom_range(0, 15)), 8'($urandom)};

		// unused kind is dropped
		plan[0]  = {1'b1, 16'h7FFF, KIND_UNUSED, 4'd15, 8'd255, 1'b1, 1'b0, NO_MSG};
		// return before any visit from a node that is no neighbor
		plan[1]  = {1'b0, 16'h0, KIND_RETURN, 4'd15, 8'd0, 1'b1, 1'b0, NO_MSG};
		// return before any visit from a neighbor
		plan[2]  = {1'b0, 16'h0, KIND_RETURN, 4'd14, 8'd2, 1'b1, 1'b0, NO_MSG};
		// full flood (or all but the parent)
		plan[3]  = {1'b1, 16'hFFFF, first_visit, 1'b0, 1'b0, NO_MSG};
		// start on a visited node is dropped
		plan[4]  = {1'b0, 16'h0, KIND_START, 4'd0, 8'd0, 1'b1, 1'b0, NO_MSG};
		// traverse to a visited node is answered with return 0
		plan[5]  = {1'b0, 16'h0, KIND_TRAVERSE, 4'd5, 8'd0, 1'b1, 1'b1,
			{4'd5, MSG_RETURN, 8'd0, 1'b1}};
		plan[6]  = {1'b0, 16'h0, KIND_TRAVERSE, 4'd0, 8'd0, 1'b1, 1'b1,
			{4'd0, MSG_RETURN, 8'd0, 1'b1}};
		plan[7]  = {1'b0, 16'h0, KIND_TRAVERSE, 4'd15, 8'd255, 1'b1, 1'b1,
			{4'd15, MSG_RETURN, 8'd0, 1'b1}};
		// returns while neighbors are still pending give nothing
		plan[8]  = {1'b0, 16'h0, KIND_RETURN, 4'd3, 8'd1, 1'b1, 1'b0, NO_MSG};
		plan[9]  = {1'b0, 16'h0, KIND_RETURN, 4'd3, 8'd200, 1'b1, 1'b0, NO_MSG};
		// count saturates
		plan[10] = {1'b0, 16'h0, KIND_RETURN, 4'd7, 8'd255, 1'b1, 1'b0, NO_MSG};
		plan[11] = {1'b0, 16'h0, KIND_UNUSED, 4'd0, 8'd0, 1'b1, 1'b0, NO_MSG};

		for (n = 0; n < ROWS; n++) begin
			if (plan[n].load) load_neighbors(plan[n].mask);
			send_item(plan[n].it, plan[n].typed, plan[n].n_want, plan[n].want);
		end

		// Random phases, each with a fresh neighbor set
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: m = 16'hFFFF;
				1: m = 16'h0001;
				2: m = 16'h8000;
				default: m = 16'($urandom_range(1, 65535));
			endcase
			load_neighbors(m);
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				pick.source = 4'($urandom_range(0, 15));
				pick.carried_count = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 3))
					: 8'($urandom_range(0, 255));
				r = $urandom_range(0, 99);
				if (r < 50) pick.kind = KIND_TRAVERSE;
				else if (r < 85) pick.kind = KIND_RETURN;
				else if (r < 93) pick.kind = KIND_START;
				else pick.kind = KIND_UNUSED;
				// keep the node alive: a return that empties the pending set would end it
				if (pick.kind == KIND_RETURN
						&& (awaiting & ~(16'd1 << pick.source)) == 16'd0)
					pick.kind = KIND_TRAVERSE;
				send_item(pick, 1'b0, 1'b0, NO_MSG);
				if (pick.kind == KIND_TRAVERSE || pick.kind == KIND_RETURN) counted++;
			end
		end

		// Empty neighbor set: the next return finishes the node, the rest is dropped
		load_neighbors(16'h0000);
		for (n = 0; n < 6; n++) begin
			pick.kind = (n == 0) ? KIND_RETURN : 2'($urandom_range(0, 3));
			pick.source = 4'($urandom_range(0, 15));
			pick.carried_count = 8'($urandom_range(0, 255));
			send_item(pick, 1'b0, 1'b0, NO_MSG);
		end

		item_valid <= 1'b0;
		while (due_msgs.size() != 0) @(posedge clk);
		repeat (TAIL) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
